@@ hdl/lfust_pkg.sv @@
// Package for the LFU slot table core: field widths, codes, state type,
// table entry layout and the controller/datapath command and status structs.
// No dependencies.
package lfust_pkg;

	localparam int ID_W     = 8;
	localparam int CNT_W    = 10;
	localparam int AGE_W    = 16;
	localparam int ACT_W    = 2;
	localparam int SLOT_W   = 4;
	localparam int CFG_W    = 5;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CNT_W-1:0] CNT_MAX    = '1;
	localparam logic [AGE_W-1:0] AGE_MAX    = '1;
	localparam logic [CFG_W-1:0] ACTIVE_RST = CFG_W'(16);

	// scan start minimum: one above the largest count
	localparam logic [CNT_W:0] MIN_START = {1'b1, {CNT_W{1'b0}}};

	// register word index (paddr[2])
	localparam logic REG_ACTIVE = 1'b0;

	localparam logic [ACT_W-1:0] ACT_HIT    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FILL   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_EVICT  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_REJECT = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINAL
	} lfust_state_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] count;
		logic [AGE_W-1:0] age;
	} lfust_entry_t;

	typedef struct packed {
		logic start;
		logic rd_en;
		logic finish;
	} lfust_cmd_t;

	typedef struct packed {
		logic in_zero;
		logic last_rd;
		logic out_free;
	} lfust_sts_t;

endpackage

@@ hdl/lfust_ctrl.sv @@
// Controller of the LFU slot table core: sequences accept, table scan,
// drain and final update. Depends on lfust_pkg.
module lfust_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  lfust_pkg::lfust_sts_t sts_i,
	output lfust_pkg::lfust_cmd_t cmd_o
);
	import lfust_pkg::*;

	lfust_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = sts_i.in_zero ? ST_FINAL : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts_i.last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				if (sts_i.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd_o    = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				cmd_o.start  = s_tvalid;
			end
			ST_SCAN: begin
				cmd_o.rd_en  = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_FINAL: begin
				cmd_o.finish = sts_i.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/lfust_dp.sv @@
// Datapath of the LFU slot table core: slot table memory with valid bits,
// scan for hit, first empty and eviction victim, aging write-back and the
// result register. Depends on lfust_pkg.
module lfust_dp #(
	parameter int SLOTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lfust_pkg::CFG_W-1:0]    active_slots,
	input  logic [lfust_pkg::ID_W-1:0]     cand_id,
	input  lfust_pkg::lfust_cmd_t          cmd_i,
	output lfust_pkg::lfust_sts_t          sts_o,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [lfust_pkg::ACT_W-1:0]    out_action,
	output logic [lfust_pkg::SLOT_W-1:0]   out_slot,
	output logic [lfust_pkg::ID_W-1:0]     out_evicted,
	output logic [lfust_pkg::CNT_W-1:0]    out_count
);
	import lfust_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = $clog2(SLOTS + 1);

	lfust_entry_t     mem_q [SLOTS];
	logic [SLOTS-1:0] vld_q;

	logic [ID_W-1:0]  id_q;
	logic             rej_q;
	logic [NW-1:0]    n_q;
	logic [NW-1:0]    n_clamp;
	logic [IW-1:0]    rd_idx_q;

	logic             rdv_s1;
	logic [IW-1:0]    wb_idx_s1;
	lfust_entry_t     rd_ent_s1;
	logic             rd_vld_s1;

	logic             hit_q, emp_q;
	logic [IW-1:0]    hit_idx_q, emp_idx_q, min_idx_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [AGE_W-1:0] hit_age_q, emp_age_q, min_age_q;
	logic [CNT_W:0]   min_cnt_q;
	logic [ID_W-1:0]  min_id_q;

	lfust_entry_t     ent;
	logic             occupied, is_hit, take_min;
	logic [AGE_W-1:0] aged_age, fill_age;
	logic [CNT_W-1:0] hit_new_cnt;

	logic             we;
	logic [IW-1:0]    wa;
	lfust_entry_t     wd;

	logic [ACT_W-1:0] fin_action;
	logic [IW-1:0]    fin_idx;
	lfust_entry_t     fin_ent;
	logic [CNT_W-1:0] fin_count;
	logic [ID_W-1:0]  fin_evicted;

	logic             out_valid_q;

	always_comb begin
		if (active_slots == '0) begin
			n_clamp = NW'(1);
		end else if (int'(active_slots) > SLOTS) begin
			n_clamp = NW'(SLOTS);
		end else begin
			n_clamp = NW'(active_slots);
		end
	end

	assign sts_o.in_zero  = (cand_id == '0);
	assign sts_o.last_rd  = ((NW'(rd_idx_q) + NW'(1)) == n_q);
	assign sts_o.out_free = !out_valid_q || out_ready;

	// entry read back, zero where never written
	assign ent      = rd_vld_s1 ? rd_ent_s1 : '0;
	assign occupied = (ent.id != '0);
	assign is_hit   = (ent.id == id_q);
	assign aged_age = (occupied && ent.age != AGE_MAX) ? ent.age + AGE_W'(1) : ent.age;
	assign take_min = ({1'b0, ent.count} < min_cnt_q) ||
	                  (({1'b0, ent.count} == min_cnt_q) && (min_age_q < ent.age));

	assign hit_new_cnt = (hit_cnt_q == CNT_MAX) ? hit_cnt_q : hit_cnt_q + CNT_W'(1);
	assign fill_age    = (emp_age_q == AGE_MAX) ? emp_age_q : emp_age_q + AGE_W'(1);

	always_comb begin
		fin_ent.id  = id_q;
		fin_evicted = '0;
		if (rej_q) begin
			fin_action    = ACT_REJECT;
			fin_idx       = '0;
			fin_ent.count = '0;
			fin_ent.age   = '0;
		end else if (hit_q) begin
			fin_action    = ACT_HIT;
			fin_idx       = hit_idx_q;
			fin_ent.count = hit_new_cnt;
			fin_ent.age   = hit_age_q;
		end else if (emp_q) begin
			fin_action    = ACT_FILL;
			fin_idx       = emp_idx_q;
			fin_ent.count = CNT_W'(1);
			fin_ent.age   = fill_age;
		end else begin
			fin_action    = ACT_EVICT;
			fin_idx       = min_idx_q;
			fin_ent.count = CNT_W'(1);
			fin_ent.age   = AGE_W'(1);
			fin_evicted   = min_id_q;
		end
		fin_count = fin_ent.count;
	end

	always_comb begin
		we = rdv_s1 || (cmd_i.finish && !rej_q);
		if (rdv_s1) begin
			wa     = wb_idx_s1;
			wd     = ent;
			wd.age = aged_age;
		end else begin
			wa = fin_idx;
			wd = fin_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.rd_en) begin
			rd_ent_s1 <= mem_q[rd_idx_q];
			rd_vld_s1 <= vld_q[rd_idx_q];
		end
		if (we) begin
			mem_q[wa] <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rej_q    <= 1'b0;
			n_q      <= '0;
			rd_idx_q <= '0;
			rdv_s1   <= 1'b0;
		end else begin
			rdv_s1 <= cmd_i.rd_en;
			if (cmd_i.start) begin
				rej_q    <= sts_o.in_zero;
				n_q      <= n_clamp;
				rd_idx_q <= '0;
			end else if (cmd_i.rd_en) begin
				rd_idx_q <= IW'(rd_idx_q + IW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.start) begin
			id_q <= cand_id;
		end
		if (cmd_i.rd_en) begin
			wb_idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			emp_q     <= 1'b0;
			min_cnt_q <= MIN_START;
		end else if (cmd_i.start) begin
			hit_q     <= 1'b0;
			emp_q     <= 1'b0;
			min_cnt_q <= MIN_START;
		end else if (rdv_s1) begin
			if (is_hit && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!occupied && !emp_q) begin
				emp_q <= 1'b1;
			end
			if (take_min) begin
				min_cnt_q <= {1'b0, ent.count};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdv_s1) begin
			if (is_hit && !hit_q) begin
				hit_idx_q <= wb_idx_s1;
				hit_cnt_q <= ent.count;
				hit_age_q <= aged_age;
			end
			if (!occupied && !emp_q) begin
				emp_idx_q <= wb_idx_s1;
				emp_age_q <= ent.age;
			end
			if (take_min) begin
				min_idx_q <= wb_idx_s1;
				min_age_q <= ent.age;
				min_id_q  <= ent.id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.finish) begin
			out_action  <= fin_action;
			out_slot    <= SLOT_W'(fin_idx);
			out_evicted <= fin_evicted;
			out_count   <= fin_count;
		end
	end

	assign out_valid = out_valid_q;

	a_fin_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.finish |-> !rdv_s1 && !cmd_i.rd_en)
		else $error("final update overlaps table scan");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.rd_en |-> (NW'(rd_idx_q) < n_q))
		else $error("scan index beyond active slots");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.finish |=> out_valid_q)
		else $error("result not presented after finish");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_action == ACT_HIT) |-> (out_count != '0))
		else $error("hit reported with zero count");

endmodule

@@ hdl/lfu_slot_table_oldest_tiebreak_core.sv @@
// Top level of the LFU slot table core: APB register, controller and datapath.
// Depends on lfust_pkg, lfust_ctrl and lfust_dp.
//
// Each id on the input stream is looked up in a table of SLOTS entries, of
// which active_slots (clamped to 1..SLOTS) are scanned. It is counted as a
// hit, placed in the first empty slot, or replaces the slot with the lowest
// count, ties going to the oldest and then to the lowest index. One result
// per id. The table sits in a single-port-read memory that is read one entry
// per cycle, and the aging write-back rides along with that scan; an id of
// zero is rejected without touching the table. One item is worked on at a
// time; a finished result waits in the output register while the next id is
// taken.
module lfu_slot_table_oldest_tiebreak_core #(
	parameter int SLOTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lfust_pkg::PADDR_W-1:0]   paddr,
	input  logic [lfust_pkg::PDATA_W-1:0]   pwdata,
	output logic [lfust_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] candidate_id
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,  // [3:0] slot, [11:4] evicted_id,
	                                                  // [21:12] hit_count, [23:22] zero
	output logic [1:0]                      m_tuser   // [1:0] action
);
	import lfust_pkg::*;

	logic [CFG_W-1:0]  active_q;
	lfust_cmd_t        cmd;
	lfust_sts_t        sts;
	logic [SLOT_W-1:0] res_slot;
	logic [ID_W-1:0]   res_evicted;
	logic [CNT_W-1:0]  res_count;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE) begin
			active_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_ACTIVE) ? PDATA_W'(active_q) : '0;

	lfust_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts_i    (sts),
		.cmd_o    (cmd)
	);

	lfust_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.active_slots (active_q),
		.cand_id      (s_tdata[ID_W-1:0]),
		.cmd_i        (cmd),
		.sts_o        (sts),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_action   (m_tuser),
		.out_slot     (res_slot),
		.out_evicted  (res_evicted),
		.out_count    (res_count)
	);

	assign m_tdata = {2'b00, res_count, res_evicted, res_slot};

endmodule

@@ tb/lfust_table_checker.sv @@
// Checker for the LFU slot table core: tracks the active_slots register, predicts
// one outcome per accepted id from its own copy of the table and compares results.
// Depends on lfust_pkg.
module lfust_table_checker #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lfust_pkg::PADDR_W-1:0] paddr,
	input  logic [lfust_pkg::PDATA_W-1:0] pwdata,
	input  logic [lfust_pkg::PDATA_W-1:0] prdata,
	input  logic                          pready,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] candidate_id
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [23:0]                   m_tdata,   // [3:0] slot, [11:4] evicted_id,
	                                                 // [21:12] hit_count, [23:22] zero
	input  logic [1:0]                    m_tuser,   // [1:0] action
	output int                            outcomes_seen,
	output int                            mismatches
);
	import lfust_pkg::*;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   evicted;
		logic [CNT_W-1:0]  count;
	} outcome_t;

	logic [ID_W-1:0]  tab_id  [SLOTS];
	logic [CNT_W-1:0] tab_cnt [SLOTS];
	logic [AGE_W-1:0] tab_age [SLOTS];
	logic [CFG_W-1:0] active_reg;
	outcome_t         pending_outcomes [$];
	outcome_t         predicted, want;
	int               k;

	task automatic age_occupied(input int n);
		for (int j = 0; j < n; j++)
			if (tab_id[j] != '0 && tab_age[j] != AGE_MAX)
				tab_age[j] = tab_age[j] + 1'b1;
	endtask

	// Looks up one id, updates the table and returns the outcome.
	task automatic record_id(input logic [ID_W-1:0] cand, output outcome_t o);
		int n, hit, free_slot, pick;
		logic [CNT_W:0] minc;
		n = int'(active_reg);
		if (n < 1)
			n = 1;
		if (n > SLOTS)
			n = SLOTS;
		o = '0;
		if (cand == '0) begin
			o.action = ACT_REJECT;
		end else begin
			hit = -1;
			free_slot = -1;
			for (int j = 0; j < n; j++) begin
				if (hit < 0 && tab_id[j] == cand)
					hit = j;
				if (free_slot < 0 && tab_id[j] == '0)
					free_slot = j;
			end
			if (hit >= 0) begin
				pick = hit;
				if (tab_cnt[pick] != CNT_MAX)
					tab_cnt[pick] = tab_cnt[pick] + 1'b1;
				age_occupied(n);
				o.action = ACT_HIT;
			end else if (free_slot >= 0) begin
				pick = free_slot;
				tab_id[pick] = cand;
				tab_cnt[pick] = CNT_W'(1);
				age_occupied(n);
				o.action = ACT_FILL;
			end else begin
				// lowest count, then strictly oldest, then lowest index
				minc = MIN_START;
				pick = 0;
				for (int j = 0; j < n; j++) begin
					if ({1'b0, tab_cnt[j]} < minc) begin
						minc = {1'b0, tab_cnt[j]};
						pick = j;
					end else if ({1'b0, tab_cnt[j]} == minc && tab_age[pick] < tab_age[j]) begin
						pick = j;
					end
				end
				o.evicted = tab_id[pick];
				tab_id[pick] = cand;
				tab_cnt[pick] = CNT_W'(1);
				age_occupied(n);
				tab_age[pick] = AGE_W'(1);
				o.action = ACT_EVICT;
			end
			o.slot = SLOT_W'(pick);
			o.count = tab_cnt[pick];
		end
	endtask

	task automatic compare_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_reg = ACTIVE_RST;
			for (k = 0; k < SLOTS; k++) begin
				tab_id[k] = '0;
				tab_cnt[k] = '0;
				tab_age[k] = '0;
			end
			pending_outcomes.delete();
			mismatches = 0;
			outcomes_seen <= 0;
		end else begin
			if (psel && penable && pready && paddr[2] == REG_ACTIVE) begin
				if (pwrite)
					active_reg = pwdata[CFG_W-1:0];
				else
					compare_field("active_slots readback", PDATA_W'(active_reg), prdata);
			end
			if (m_tvalid && m_tready) begin
				outcomes_seen <= outcomes_seen + 1;
				if (pending_outcomes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual action %0d data %h",
						$time, m_tuser, m_tdata);
				end else begin
					want = pending_outcomes.pop_front();
					compare_field("action", 32'(want.action), 32'(m_tuser));
					compare_field("slot", 32'(want.slot), 32'(m_tdata[3:0]));
					compare_field("evicted_id", 32'(want.evicted), 32'(m_tdata[11:4]));
					compare_field("hit_count", 32'(want.count), 32'(m_tdata[21:12]));
					compare_field("tdata pad", 32'(0), 32'(m_tdata[23:22]));
				end
			end
			if (s_tvalid && s_tready) begin
				record_id(s_tdata, predicted);
				pending_outcomes.push_back(predicted);
			end
		end
	end

endmodule

@@ tb/lfu_slot_table_oldest_tiebreak_core_tb.sv @@
// Testbench top for the LFU slot table core: clock, reset, APB setup of
// active_slots, id stimulus with random idling, and the verdict.
// Depends on lfust_pkg, lfu_slot_table_oldest_tiebreak_core and lfust_table_checker.
module lfu_slot_table_oldest_tiebreak_core_tb;
	import lfust_pkg::*;

	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam logic [PADDR_W-1:0] ACTIVE_ADDR = {REG_ACTIVE, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic               s_tvalid, s_tready;
	logic [7:0]         s_tdata;
	logic               m_tvalid, m_tready;
	logic [23:0]        m_tdata;
	logic [1:0]         m_tuser;

	int send_idle_pct = 31;
	int recv_idle_pct = 47;
	int sent_cnt = 0;
	int cycles = 0;
	int outcomes_seen, mismatches;

	lfu_slot_table_oldest_tiebreak_core #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	lfust_table_checker #(.SLOTS(SLOTS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.outcomes_seen(outcomes_seen), .mismatches(mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_id(input logic [ID_W-1:0] id);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= id;
		do @(posedge clk); while (!s_tready);
		sent_cnt++;
	endtask

	// stop sending and wait until every outcome has been transferred
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outcomes_seen != sent_cnt);
	endtask

	// write active_slots, then read it back
	task automatic set_active_slots(input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ACTIVE_ADDR;
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] settings [9];
		logic [ID_W-1:0]  id_pool [32];
		logic [ID_W-1:0]  id;
		int               n, pool_size, r;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fills, hits, reject, evictions, clamping, parked slots
		send_id(8'd255);
		send_id(8'd1);
		send_id(8'd0);
		send_id(8'd255);
		send_id(8'd128);
		send_id(8'd1);
		drain();
		set_active_slots(CFG_W'(2));
		send_id(8'd7);
		send_id(8'd128);
		send_id(8'd9);
		drain();
		set_active_slots(CFG_W'(0));
		send_id(8'd1);
		send_id(8'd1);
		drain();
		set_active_slots(CFG_W'(31));
		send_id(8'd128);
		send_id(8'd64);
		drain();
		set_active_slots(CFG_W'(17));
		send_id(8'd0);
		send_id(8'd255);
		drain();

		settings = '{CFG_W'(16), CFG_W'(1), CFG_W'(8), CFG_W'(0), CFG_W'(31),
			CFG_W'(3), CFG_W'(17), CFG_W'($urandom_range(1, 16)), CFG_W'(16)};
		for (int sub = 0; sub < 9; sub++) begin
			case (sub / 3)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 47;
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_active_slots(settings[sub]);
			n = int'(settings[sub]);
			if (n < 1)
				n = 1;
			if (n > SLOTS)
				n = SLOTS;
			// a few more ids than slots, so hits and evictions both occur
			pool_size = n + n / 2 + 1;
			for (int k = 0; k < pool_size; k++)
				id_pool[k] = ID_W'($urandom_range(1, 255));
			for (int k = 0; k < 56; k++) begin
				r = $urandom_range(0, 99);
				if (r < 5)
					id = '0;
				else if (r < 20)
					id = ID_W'($urandom_range(1, 255));
				else
					id = id_pool[$urandom_range(0, pool_size - 1)];
				send_id(id);
				if (k == 28)
					drain();
			end
			drain();
		end

		repeat (2 * SLOTS + 8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
